// ===== sv/mftp_pkg.sv =====
// Shared constants, types and helpers for the MIDI file track event player.
`default_nettype none
package mftp_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0]  BYTE_META   = 8'hFF;
    localparam logic [7:0]  BYTE_SYSEX  = 8'hF0;
    localparam logic [7:0]  BYTE_ESC    = 8'hF7;
    localparam logic [7:0]  META_TEMPO  = 8'h51;
    localparam logic [3:0]  STAT_PROG   = 4'hC;
    localparam logic [3:0]  STAT_PRESS  = 4'hD;

    localparam logic [23:0] TEMPO_RESET = 24'd500000;
    localparam logic [15:0] TPQ_RESET   = 16'd96;
    localparam logic [8:0]  MS_CAP      = 9'd500;
    localparam logic [31:0] CAP_LIMIT   = 32'd501000;
    localparam logic [18:0] MS_DIV_TOP  = 19'(1000 << 8);

    localparam logic [4:0]  Q_STEPS     = 5'd23;
    localparam logic [4:0]  MUL_STEPS   = 5'd23;
    localparam logic [4:0]  MS_STEPS    = 5'd8;

    localparam logic        REG_TPQ     = 1'b0;

    typedef enum logic [7:0] {
        PH_DELTA      = 8'b0000_0001,
        PH_EVENT      = 8'b0000_0010,
        PH_DATA       = 8'b0000_0100,
        PH_META_TYPE  = 8'b0000_1000,
        PH_META_LEN   = 8'b0001_0000,
        PH_META_BODY  = 8'b0010_0000,
        PH_SYSEX_LEN  = 8'b0100_0000,
        PH_SYSEX_BODY = 8'b1000_0000
    } phase_t;

    typedef enum logic [5:0] {
        C_IDLE  = 6'b00_0001,
        C_QDIV  = 6'b00_0010,
        C_MUL   = 6'b00_0100,
        C_CAP   = 6'b00_1000,
        C_MSDIV = 6'b01_0000,
        C_EMIT  = 6'b10_0000
    } ctrl_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] midi_byte;
        logic [8:0] delay_ms;
        logic       run_end;
    } res_t;

    function automatic logic [1:0] data_count(input logic [7:0] status);
        logic [3:0] hi;
        hi = status[7:4];
        return (hi == STAT_PROG || hi == STAT_PRESS) ? 2'd1 : 2'd2;
    endfunction

endpackage
`default_nettype wire

// ===== sv/midi_file_track_event_player.sv =====
// MIDI file track event player: track-body parser with bit-serial delay unit.
// Usage: feed the body of one track, one byte per transfer, on s_tdata[7:0];
// s_tlast marks the final byte, after which all parse state returns to its
// reset values (ticks_per_quarter is kept). Each byte yields zero, one or two
// results on the m_ channel: m_tuser = 0 carries a MIDI byte in m_tdata[7:0],
// m_tuser = 1 a delay in ms (1..500) in m_tdata[16:8]; m_tlast marks the
// last result of one input byte. ticks_per_quarter lives at APB address 0.
// Flow: a byte that ends no delta does not occupy the delay unit, and its
// results are written to the result queue as it is accepted. A byte that
// closes a nonzero delta occupies the delay unit, during which input waits:
// restoring division tempo/division, shift-add multiply, one cap compare,
// division by 1000 (skipped when the cap applies) and one emit step. Input
// is taken while a 4-entry result queue has room for two results, so a
// stalled receiver only holds input once fewer than two entries are free;
// results are never dropped. Reset empties the queue and restores tempo
// 500000 us, division 96 and the delta-time phase.
`default_nettype none
module midi_file_track_event_player
    import mftp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] track_byte
    input  wire logic        s_tlast,   // end_of_track
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] midi_byte, [16:8] delay_ms, rest zero
    output logic             m_tuser,   // result_kind
    output logic             m_tlast,   // run_end
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0]        tpq_reg;
    phase_t             phase_reg, phase_next;
    ctrl_t              ctrl_reg, ctrl_next;
    logic [31:0]        vlq_reg, vlq_next;
    logic [7:0]         rstat_reg, rstat_next;
    logic [23:0]        tempo_reg, tempo_next;
    logic [23:0]        ptempo_reg, ptempo_next;
    logic [31:0]        remain_reg, remain_next;
    logic [7:0]         mkind_reg, mkind_next;
    logic [1:0]         midx_reg, midx_next;
    logic [1:0]         dleft_reg, dleft_next;

    logic [23:0]        num_reg, num_next;
    logic [15:0]        den_reg, den_next;
    logic [15:0]        rem_reg, rem_next;
    logic [31:0]        mc_reg, mc_next;
    logic [31:0]        prod_reg, prod_next;
    logic [18:0]        msrem_reg, msrem_next;
    logic [18:0]        dsh_reg, dsh_next;
    logic [8:0]         quo_reg, quo_next;
    logic [4:0]         cnt_reg, cnt_next;

    res_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next, wr_ptr1;
    logic [FIFO_AW:0]   count_reg, count_next;

    logic               s_fire, pop, wr0, wr1, cfg_wr;
    res_t               wr0_data, wr1_data;
    logic [7:0]         b;
    logic [31:0]        accum_shift, remain_dec;
    logic [15:0]        eff_div;
    logic [16:0]        trial;
    logic               q_ge, ms_ge;
    logic [1:0]         cnt_run, dleft_dec, midx_inc;
    logic [23:0]        pt_new;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_TPQ);
    assign prdata   = (paddr[2] == REG_TPQ) ? {16'b0, tpq_reg} : 32'b0;

    assign s_tready = (ctrl_reg == C_IDLE) && (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tuser  = fifo_reg[rd_ptr_reg].result_kind;
    assign m_tlast  = fifo_reg[rd_ptr_reg].run_end;
    assign m_tdata  = {7'b0, fifo_reg[rd_ptr_reg].delay_ms, fifo_reg[rd_ptr_reg].midi_byte};
    assign wr_ptr1  = wr_ptr_reg + FIFO_AW'(1);

    assign b           = s_tdata;
    assign accum_shift = {vlq_reg[24:0], b[6:0]};
    assign remain_dec  = remain_reg - 32'd1;
    assign dleft_dec   = dleft_reg - 2'd1;
    assign midx_inc    = midx_reg + 2'd1;
    assign pt_new      = {ptempo_reg[15:0], b};
    assign cnt_run     = data_count(rstat_reg) - 2'd1;
    assign eff_div     = (tpq_reg == '0 || tpq_reg[15]) ? TPQ_RESET : tpq_reg;
    assign trial       = {rem_reg, num_reg[23]};
    assign q_ge        = trial >= {1'b0, den_reg};
    assign ms_ge       = msrem_reg >= dsh_reg;

    always_comb begin
        phase_next  = phase_reg;
        vlq_next    = vlq_reg;
        rstat_next  = rstat_reg;
        tempo_next  = tempo_reg;
        ptempo_next = ptempo_reg;
        remain_next = remain_reg;
        mkind_next  = mkind_reg;
        midx_next   = midx_reg;
        dleft_next  = dleft_reg;
        ctrl_next   = ctrl_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        mc_next     = mc_reg;
        prod_next   = prod_reg;
        msrem_next  = msrem_reg;
        dsh_next    = dsh_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        wr0         = 1'b0;
        wr1         = 1'b0;
        wr0_data    = '0;
        wr1_data    = '0;

        if (s_fire) begin
            unique case (phase_reg)
                PH_DELTA: begin
                    vlq_next = accum_shift;
                    if (!b[7] || s_tlast) begin
                        if (accum_shift != '0) begin
                            num_next  = tempo_reg;
                            den_next  = eff_div;
                            rem_next  = '0;
                            mc_next   = accum_shift;
                            prod_next = '0;
                            cnt_next  = Q_STEPS;
                            ctrl_next = C_QDIV;
                        end
                        vlq_next   = '0;
                        phase_next = PH_EVENT;
                    end
                end
                PH_EVENT: begin
                    if (b == BYTE_META) begin
                        phase_next = PH_META_TYPE;
                    end else if (b == BYTE_SYSEX || b == BYTE_ESC) begin
                        if (b == BYTE_SYSEX) begin
                            wr0               = 1'b1;
                            wr0_data.midi_byte = BYTE_SYSEX;
                        end
                        vlq_next   = '0;
                        phase_next = PH_SYSEX_LEN;
                    end else if (b[7]) begin
                        rstat_next         = b;
                        wr0                = 1'b1;
                        wr0_data.midi_byte = b;
                        dleft_next         = data_count(b);
                        phase_next         = PH_DATA;
                    end else begin
                        wr0                = 1'b1;
                        wr0_data.midi_byte = rstat_reg;
                        wr1                = 1'b1;
                        wr1_data.midi_byte = b;
                        dleft_next         = cnt_run;
                        phase_next         = (cnt_run == '0) ? PH_DELTA : PH_DATA;
                    end
                end
                PH_DATA: begin
                    wr0                = 1'b1;
                    wr0_data.midi_byte = b;
                    dleft_next         = dleft_dec;
                    if (dleft_dec == '0) begin
                        phase_next = PH_DELTA;
                    end
                end
                PH_META_TYPE: begin
                    mkind_next = b;
                    vlq_next   = '0;
                    phase_next = PH_META_LEN;
                end
                PH_META_LEN: begin
                    vlq_next = accum_shift;
                    if (!b[7]) begin
                        remain_next = accum_shift;
                        vlq_next    = '0;
                        ptempo_next = '0;
                        midx_next   = (mkind_reg == META_TEMPO && accum_shift >= 32'd3)
                                      ? 2'd0 : 2'd3;
                        phase_next  = (accum_shift == '0) ? PH_DELTA : PH_META_BODY;
                    end
                end
                PH_META_BODY: begin
                    if (midx_reg != 2'd3) begin
                        ptempo_next = pt_new;
                        midx_next   = midx_inc;
                        if (midx_inc == 2'd3) begin
                            tempo_next = pt_new;
                        end
                    end
                    remain_next = remain_dec;
                    if (remain_dec == '0) begin
                        phase_next = PH_DELTA;
                    end
                end
                PH_SYSEX_LEN: begin
                    vlq_next = accum_shift;
                    if (!b[7]) begin
                        remain_next = accum_shift;
                        vlq_next    = '0;
                        phase_next  = (accum_shift == '0) ? PH_DELTA : PH_SYSEX_BODY;
                    end
                end
                PH_SYSEX_BODY: begin
                    wr0                = 1'b1;
                    wr0_data.midi_byte = b;
                    remain_next        = remain_dec;
                    if (remain_dec == '0) begin
                        phase_next = PH_DELTA;
                    end
                end
                default: begin
                    phase_next = PH_DELTA;
                end
            endcase
            wr0_data.run_end = !wr1;
            wr1_data.run_end = 1'b1;

            if (s_tlast) begin
                phase_next  = PH_DELTA;
                vlq_next    = '0;
                rstat_next  = '0;
                tempo_next  = TEMPO_RESET;
                ptempo_next = '0;
                remain_next = '0;
                mkind_next  = '0;
                midx_next   = '0;
                dleft_next  = '0;
            end
        end

        unique case (ctrl_reg)
            C_IDLE: begin
            end
            C_QDIV: begin
                rem_next = q_ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
                num_next = {num_reg[22:0], q_ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    cnt_next  = MUL_STEPS;
                    ctrl_next = C_MUL;
                end
            end
            C_MUL: begin
                if (num_reg[0]) begin
                    prod_next = prod_reg + mc_reg;
                end
                mc_next  = {mc_reg[30:0], 1'b0};
                num_next = {1'b0, num_reg[23:1]};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    ctrl_next = C_CAP;
                end
            end
            C_CAP: begin
                if (prod_reg >= CAP_LIMIT) begin
                    quo_next  = MS_CAP;
                    ctrl_next = C_EMIT;
                end else begin
                    msrem_next = prod_reg[18:0];
                    dsh_next   = MS_DIV_TOP;
                    quo_next   = '0;
                    cnt_next   = MS_STEPS;
                    ctrl_next  = C_MSDIV;
                end
            end
            C_MSDIV: begin
                if (ms_ge) begin
                    msrem_next = msrem_reg - dsh_reg;
                end
                quo_next = {quo_reg[7:0], ms_ge};
                dsh_next = {1'b0, dsh_reg[18:1]};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    ctrl_next = C_EMIT;
                end
            end
            C_EMIT: begin
                if (quo_reg != '0) begin
                    wr0                  = 1'b1;
                    wr0_data.result_kind = 1'b1;
                    wr0_data.delay_ms    = quo_reg;
                    wr0_data.run_end     = 1'b1;
                end
                ctrl_next = C_IDLE;
            end
            default: begin
                ctrl_next = C_IDLE;
            end
        endcase

        wr_ptr_next = wr_ptr_reg + FIFO_AW'(wr0) + FIFO_AW'(wr1);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW+1)'(wr0) + (FIFO_AW+1)'(wr1)
                      - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpq_reg    <= TPQ_RESET;
            phase_reg  <= PH_DELTA;
            ctrl_reg   <= C_IDLE;
            vlq_reg    <= '0;
            rstat_reg  <= '0;
            tempo_reg  <= TEMPO_RESET;
            ptempo_reg <= '0;
            remain_reg <= '0;
            mkind_reg  <= '0;
            midx_reg   <= '0;
            dleft_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg_wr) begin
                tpq_reg <= pwdata[15:0];
            end
            phase_reg  <= phase_next;
            ctrl_reg   <= ctrl_next;
            vlq_reg    <= vlq_next;
            rstat_reg  <= rstat_next;
            tempo_reg  <= tempo_next;
            ptempo_reg <= ptempo_next;
            remain_reg <= remain_next;
            mkind_reg  <= mkind_next;
            midx_reg   <= midx_next;
            dleft_reg  <= dleft_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        mc_reg    <= mc_next;
        prod_reg  <= prod_next;
        msrem_reg <= msrem_next;
        dsh_reg   <= dsh_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        if (wr0) begin
            fifo_reg[wr_ptr_reg] <= wr0_data;
        end
        if (wr1) begin
            fifo_reg[wr_ptr1] <= wr1_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/mftp_checker.sv =====
// Port-level checker for the MIDI file track event player, bound to the top level.
`default_nettype none
module mftp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_delay_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata[7:0] == 8'd0
                                && m_tdata[16:8] != 9'd0 && m_tdata[16:8] <= 9'd500
                                && m_tdata[23:17] == 7'd0)
        else $error("malformed delay transfer");

    a_byte_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[23:8] == 16'd0)
        else $error("malformed byte transfer");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind midi_file_track_event_player mftp_checker u_mftp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== dv/midi_file_track_event_player_tb.sv =====
// Self-checking testbench for the MIDI file track event player: stream and APB stimulus.
import mftp_pkg::*;

class track_player_sb;
    logic [15:0] tpq;
    phase_t      ph;
    logic [31:0] vlq;
    logic [31:0] body_left;
    logic [7:0]  run_status;
    logic [7:0]  meta_type;
    logic [23:0] tempo;
    logic [23:0] tempo_acc;
    logic [1:0]  meta_idx;
    logic [1:0]  data_left;
    res_t        step_q[$];
    res_t        expected_q[$];
    int          errors;

    function new();
        tpq    = TPQ_RESET;
        errors = 0;
        clear_parse();
    endfunction

    function void clear_parse();
        ph         = PH_DELTA;
        vlq        = '0;
        body_left  = '0;
        run_status = '0;
        meta_type  = '0;
        tempo      = TEMPO_RESET;
        tempo_acc  = '0;
        meta_idx   = '0;
        data_left  = '0;
    endfunction

    function logic [8:0] delay_ms_of(logic [31:0] ticks);
        logic [31:0] div;
        logic [31:0] per_tick;
        logic [31:0] prod;
        logic [31:0] ms;
        div = {16'd0, tpq};
        if (tpq == 16'd0 || tpq[15]) div = {16'd0, TPQ_RESET};
        per_tick = {8'd0, tempo} / div;
        prod     = ticks * per_tick;
        ms       = prod / 32'd1000;
        if (ms > {23'd0, MS_CAP}) ms = {23'd0, MS_CAP};
        return ms[8:0];
    endfunction

    function logic [1:0] msg_len(logic [7:0] st);
        return (st[7:4] == STAT_PROG || st[7:4] == STAT_PRESS) ? 2'd1 : 2'd2;
    endfunction

    function void add(logic kind, logic [7:0] v, logic [8:0] ms);
        res_t r;
        r.result_kind = kind;
        r.midi_byte   = v;
        r.delay_ms    = ms;
        r.run_end     = 1'b0;
        step_q.push_back(r);
    endfunction

    // predict the results of one accepted track byte
    function void note_input(logic [7:0] b, logic eot);
        logic [31:0] acc;
        logic [8:0]  ms;
        res_t        r;
        step_q.delete();
        acc = {vlq[24:0], b[6:0]};
        case (ph)
            PH_DELTA: begin
                vlq = acc;
                if (!b[7] || eot) begin
                    if (vlq != 32'd0) begin
                        ms = delay_ms_of(vlq);
                        if (ms != 9'd0) add(1'b1, 8'd0, ms);
                    end
                    vlq = '0;
                    ph  = PH_EVENT;
                end
            end
            PH_EVENT: begin
                if (b == BYTE_META) begin
                    ph = PH_META_TYPE;
                end else if (b == BYTE_SYSEX || b == BYTE_ESC) begin
                    if (b == BYTE_SYSEX) add(1'b0, BYTE_SYSEX, 9'd0);
                    vlq = '0;
                    ph  = PH_SYSEX_LEN;
                end else if (b[7]) begin
                    run_status = b;
                    add(1'b0, b, 9'd0);
                    data_left = msg_len(b);
                    ph        = PH_DATA;
                end else begin
                    add(1'b0, run_status, 9'd0);
                    add(1'b0, b, 9'd0);
                    data_left = msg_len(run_status) - 2'd1;
                    ph        = (data_left == 2'd0) ? PH_DELTA : PH_DATA;
                end
            end
            PH_DATA: begin
                add(1'b0, b, 9'd0);
                data_left = data_left - 2'd1;
                if (data_left == 2'd0) ph = PH_DELTA;
            end
            PH_META_TYPE: begin
                meta_type = b;
                vlq       = '0;
                ph        = PH_META_LEN;
            end
            PH_META_LEN: begin
                vlq = acc;
                if (!b[7]) begin
                    body_left = vlq;
                    vlq       = '0;
                    tempo_acc = '0;
                    meta_idx  = (meta_type == META_TEMPO && body_left >= 32'd3) ? 2'd0 : 2'd3;
                    ph        = (body_left == 32'd0) ? PH_DELTA : PH_META_BODY;
                end
            end
            PH_META_BODY: begin
                if (meta_idx < 2'd3) begin
                    tempo_acc = {tempo_acc[15:0], b};
                    meta_idx  = meta_idx + 2'd1;
                    if (meta_idx == 2'd3) tempo = tempo_acc;
                end
                body_left = body_left - 32'd1;
                if (body_left == 32'd0) ph = PH_DELTA;
            end
            PH_SYSEX_LEN: begin
                vlq = acc;
                if (!b[7]) begin
                    body_left = vlq;
                    vlq       = '0;
                    ph        = (body_left == 32'd0) ? PH_DELTA : PH_SYSEX_BODY;
                end
            end
            default: begin
                add(1'b0, b, 9'd0);
                body_left = body_left - 32'd1;
                if (body_left == 32'd0) ph = PH_DELTA;
            end
        endcase
        for (int i = 0; i < step_q.size(); i++) begin
            r         = step_q[i];
            r.run_end = (i == step_q.size() - 1);
            expected_q.push_back(r);
        end
        if (eot) clear_parse();
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 50) $display("MISMATCH: %s", msg);
    endtask

    task check(res_t got);
        res_t want;
        if (expected_q.size() == 0) begin
            report($sformatf("unexpected result kind=%0d byte=%02h ms=%0d last=%0d",
                             got.result_kind, got.midi_byte, got.delay_ms, got.run_end));
            return;
        end
        want = expected_q.pop_front();
        if (got.result_kind !== want.result_kind)
            report($sformatf("kind %0d, want %0d", got.result_kind, want.result_kind));
        if (got.midi_byte !== want.midi_byte)
            report($sformatf("midi byte %02h, want %02h", got.midi_byte, want.midi_byte));
        if (got.delay_ms !== want.delay_ms)
            report($sformatf("delay %0d ms, want %0d ms", got.delay_ms, want.delay_ms));
        if (got.run_end !== want.run_end)
            report($sformatf("last %0d, want %0d", got.run_end, want.run_end));
    endtask
endclass

module midi_file_track_event_player_tb;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          SETTLE_CYCLES  = 100;
    localparam int          PHASE_ITEMS    = 160;
    localparam int          NUM_DIRECTED   = 27;
    localparam logic [2:0]  TPQ_ADDR       = {REG_TPQ, 2'b00};
    localparam logic [7:0]  META_END       = 8'h2F;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } track_item_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;   // [7:0] midi_byte, [16:8] delay_ms
    wire         m_tuser;   // result_kind
    wire         m_tlast;   // run_end
    wire  [31:0] prdata;
    wire         pready;

    track_player_sb sb;
    track_item_t    track_q[$];
    logic [7:0]     gen_status;
    bit             quiet   = 1'b0;
    int             src_pct = 20;
    int             snk_pct = 20;
    int             stall_left = 0;
    int             idle_cycles = 0;
    int             phase_items;
    logic [15:0]    div_set[8];

    // bit 8 flags the last byte of a track
    logic [8:0] directed[NUM_DIRECTED] = '{
        9'h005, 9'h040, 9'h07F,
        9'h07F, 9'h0C3, 9'h005,
        9'h000, 9'h0FF, 9'h051, 9'h003, 9'h00F, 9'h042, 9'h040,
        9'h000, 9'h0F0, 9'h001, 9'h07E,
        9'h08F, 9'h0FF, 9'h0FF, 9'h07F, 9'h1F5,
        9'h000, 9'h0F0, 9'h005, 9'h101,
        9'h185
    };

    midi_file_track_event_player uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (quiet || snk_pct == 0) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < snk_pct) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        res_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.result_kind = m_tuser;
                got.midi_byte   = m_tdata[7:0];
                got.delay_ms    = m_tdata[16:8];
                got.run_end     = m_tlast;
                sb.check(got);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [7:0] v, logic last);
        if (!quiet && $urandom_range(0, 99) < src_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(v, last);
        phase_items++;
        @(negedge aclk);
    endtask

    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_division(logic [15:0] value);
        logic [31:0] rd;
        apb_access(1'b0, TPQ_ADDR, 32'd0, rd);
        if (rd[15:0] !== value)
            sb.report($sformatf("ticks_per_quarter reads %04h, want %04h", rd[15:0], value));
    endtask

    task automatic set_division(logic [15:0] value);
        logic [31:0] wd;
        logic [31:0] rd;
        wd       = $urandom;
        wd[15:0] = value;
        apb_access(1'b1, TPQ_ADDR, wd, rd);
        sb.tpq = value;
        check_division(value);
    endtask

    // all results in, then let the delay unit finish a zero-length delay
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic void put_byte(logic [7:0] v);
        track_item_t it;
        it.data = v;
        it.last = 1'b0;
        track_q.push_back(it);
    endfunction

    function automatic logic [7:0] data_value();
        if ($urandom_range(0, 19) == 0) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic void put_delta();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            put_byte(8'd0);
        end else if (pick < 80) begin
            put_byte(8'($urandom_range(1, 127)));
        end else if (pick < 95) begin
            put_byte(8'($urandom_range(128, 130)));
            put_byte(8'($urandom_range(0, 127)));
        end else begin
            repeat ($urandom_range(2, 4)) put_byte(8'($urandom_range(128, 255)));
            put_byte(8'($urandom_range(0, 127)));
        end
    endfunction

    function automatic void put_len(int n);
        if ($urandom_range(0, 7) == 0) put_byte(8'h80);
        put_byte(8'(n));
    endfunction

    function automatic int data_bytes(logic [7:0] st);
        return (st[7:4] == STAT_PROG || st[7:4] == STAT_PRESS) ? 1 : 2;
    endfunction

    function automatic void put_event();
        int         pick;
        int         n;
        int         k;
        logic [7:0] st;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            st = 8'($urandom_range(128, 239));
            gen_status = st;
            put_byte(st);
            repeat (data_bytes(st)) put_byte(data_value());
        end else if (pick < 48) begin
            put_byte(8'($urandom_range(0, 127)));
            repeat (data_bytes(gen_status) - 1) put_byte(data_value());
        end else if (pick < 63) begin
            put_byte(BYTE_META);
            if ($urandom_range(0, 1) == 1) begin
                put_byte(META_TEMPO);
                n = ($urandom_range(0, 99) < 80) ? 3 : $urandom_range(0, 5);
                put_len(n);
                for (int i = 0; i < n; i++) begin
                    k = $urandom_range(0, 9);
                    if (i != 0)      put_byte(8'($urandom));
                    else if (k == 0) put_byte(8'h00);
                    else if (k == 1) put_byte(8'hFF);
                    else             put_byte(8'($urandom_range(1, 15)));
                end
            end else begin
                put_byte(8'($urandom));
                n = $urandom_range(0, 5);
                put_len(n);
                repeat (n) put_byte(8'($urandom));
            end
        end else if (pick < 73) begin
            put_byte(BYTE_SYSEX);
            n = $urandom_range(0, 6);
            put_len(n);
            if (n > 0) begin
                repeat (n - 1) put_byte(data_value());
                put_byte(BYTE_ESC);
            end
        end else if (pick < 78) begin
            put_byte(BYTE_ESC);
            n = $urandom_range(0, 3);
            put_len(n);
            repeat (n) put_byte(8'($urandom));
        end else if (pick < 85) begin
            st = 8'($urandom_range(241, 254));
            if (st == BYTE_ESC) st = BYTE_ESC - 8'd1;
            gen_status = st;
            put_byte(st);
            repeat (2) put_byte(data_value());
        end else begin
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
        end
    endfunction

    function automatic void build_track();
        int          keep;
        track_item_t it;
        track_q.delete();
        gen_status = 8'd0;
        repeat ($urandom_range(2, 12)) begin
            put_delta();
            put_event();
        end
        if ($urandom_range(0, 3) == 0) begin
            keep = $urandom_range(1, track_q.size());
            while (track_q.size() > keep) void'(track_q.pop_back());
        end else begin
            put_byte(8'd0);
            put_byte(BYTE_META);
            put_byte(META_END);
            put_byte(8'd0);
        end
        it      = track_q.pop_back();
        it.last = 1'b1;
        track_q.push_back(it);
    endfunction

    task automatic play_track();
        for (int i = 0; i < track_q.size(); i++)
            send_byte(track_q[i].data, track_q[i].last);
    endtask

    function automatic int idle_level();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 45;
        endcase
    endfunction

    initial begin
        sb = new();
        div_set = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF, 16'd480,
                    16'($urandom), TPQ_RESET};
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        check_division(TPQ_RESET);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_byte(directed[i][7:0], directed[i][8]);
        drain();

        for (int p = 0; p < 8; p++) begin
            set_division(div_set[p]);
            quiet = (p == 7);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                src_pct = idle_level();
                snk_pct = idle_level();
                build_track();
                play_track();
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
